// File: rtl/jpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpq_pkg
// Shared codes and types for the job priority queue: operation and status
// codes, the id width and the compare unit's result bundle.
// ----------------------------------------------------------------------------
package jpq_pkg;

   localparam int ID_BITS     = 32;
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_TAKE  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_FIND  = 2'd2;
   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd3;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_BUSY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NONE = 2'd3;

   typedef struct packed {
      logic prio_lower;  // entry priority below the key priority
      logic id_match;    // entry id equals the key id
   } cmp_result_type;

endpackage

// File: rtl/job_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_priority_queue_core
// Bounded job queue in priority order. Jobs of equal priority leave in
// arrival order. Add / take / find / clear, one response per request.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_ready  operation, job_tag, priority_req,
//                                              job_idle, find_id
//  rsp_      out        rsp_valid / rsp_ready  status, job_id, out_tag,
//                                              queue_count, nonempty
//
//  Add walks past the jobs of lower priority, take shifts the remaining jobs
//    down, find scans from the head to the match; clear and rejected requests
//    go straight to the response. The single read port of the entry RAM
//    sets this pace: entries are walked and shifted one per cycle.
//  Reset (synchronous) empties the queue and zeroes the id counter; no
//    clearing pass, the entry RAM's read data is only used below the fill count.
//  A finished response waits in the output register while the next request
//    is taken; a response that finds that register still full stalls there.
//
module job_priority_queue_core #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int TAG_BITS      = 16,
   parameter int PRIORITY_BITS = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [jpq_pkg::OP_BITS-1:0]            req_operation,
   input  logic [TAG_BITS-1:0]                    req_job_tag,
   input  logic [PRIORITY_BITS-1:0]               req_priority_req,
   input  logic                                   req_job_idle,
   input  logic [jpq_pkg::ID_BITS-1:0]            req_find_id,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [jpq_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [jpq_pkg::ID_BITS-1:0]            rsp_job_id,
   output logic [TAG_BITS-1:0]                    rsp_out_tag,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]       rsp_queue_count,
   output logic                                   rsp_nonempty
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = jpq_pkg::ID_BITS;
   localparam int EW = TAG_BITS + PRIORITY_BITS + IW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_CMP,    // walk from the tail, shifting lower-priority entries up
      S_ADD_PUT,    // write the new entry at the slot found
      S_TAKE_HEAD,  // head entry arrives from the RAM
      S_TAKE_SHIFT, // move the remaining entries down one slot
      S_FIND,       // scan from the head for a matching id
      S_RESP        // hand the result to the output register
   } state_type;

   state_type                        state_ff;
   logic [CW-1:0]                    occ_ff;
   logic [CW-1:0]                    idx_ff;
   logic [IW-1:0]                    next_id_ff;
   logic [TAG_BITS-1:0]              key_tag_ff;
   logic [PRIORITY_BITS-1:0]         key_prio_ff;
   logic [IW-1:0]                    key_id_ff;
   logic [jpq_pkg::STATUS_BITS-1:0]  res_status_ff;
   logic [IW-1:0]                    res_id_ff;
   logic [TAG_BITS-1:0]              res_tag_ff;

   logic                             rsp_valid_ff;
   logic [jpq_pkg::STATUS_BITS-1:0]  rsp_status_ff;
   logic [IW-1:0]                    rsp_job_id_ff;
   logic [TAG_BITS-1:0]              rsp_out_tag_ff;
   logic [CW-1:0]                    rsp_count_ff;

   // RAM ports
   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic [EW-1:0]                    wr_data;
   logic [CW-1:0]                    rd_addr_full;
   logic [CW-1:0]                    wr_addr_full;
   logic [EW-1:0]                    rd_data;

   // fields of the entry just read
   logic [TAG_BITS-1:0]              ent_tag;
   logic [PRIORITY_BITS-1:0]         ent_prio;
   logic [IW-1:0]                    ent_id;
   logic [EW-1:0]                    new_entry;

   jpq_pkg::cmp_result_type          cmp;
   logic                             rsp_free;
   logic                             last_idx;

   assign ent_tag   = rd_data[TAG_BITS-1:0];
   assign ent_prio  = rd_data[TAG_BITS +: PRIORITY_BITS];
   assign ent_id    = rd_data[TAG_BITS+PRIORITY_BITS +: IW];
   assign new_entry = {key_id_ff, key_prio_ff, key_tag_ff};

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign last_idx  = ((idx_ff + CW'(1)) == occ_ff);
   assign req_ready = (state_ff == S_IDLE);

   // read address: issued in the cycle before its data is used
   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_operation == jpq_pkg::OP_ADD) begin
               rd_addr_full = occ_ff - CW'(1);
            end else begin
               rd_addr_full = '0;
            end
         end
         S_ADD_CMP:    rd_addr_full = idx_ff - CW'(2);
         S_TAKE_HEAD:  rd_addr_full = idx_ff;
         S_TAKE_SHIFT: rd_addr_full = idx_ff + CW'(1);
         S_FIND:       rd_addr_full = idx_ff + CW'(1);
         default:      rd_addr_full = '0;
      endcase
   end

   // write port: shifts and the final insert
   always_comb begin
      wr_en        = 1'b0;
      wr_addr_full = idx_ff;
      wr_data      = new_entry;
      unique case (state_ff)
         S_ADD_CMP: begin
            wr_en = 1'b1;
            if (cmp.prio_lower) begin
               wr_data = rd_data;
            end
         end
         S_ADD_PUT: begin
            wr_en = 1'b1;
         end
         S_TAKE_SHIFT: begin
            wr_en        = 1'b1;
            wr_addr_full = idx_ff - CW'(1);
            wr_data      = rd_data;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign wr_addr = wr_addr_full[AW-1:0];

   jpq_entry_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_full[AW-1:0]),
      .rd_data (rd_data)
   );

   jpq_cmp #(
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_cmp (
      .entry_prio (ent_prio),
      .entry_id   (ent_id),
      .key_prio   (key_prio_ff),
      .key_id     (key_id_ff),
      .result     (cmp)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         next_id_ff   <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  key_tag_ff  <= req_job_tag;
                  key_prio_ff <= req_priority_req;
                  key_id_ff   <= req_find_id;
                  res_tag_ff  <= '0;
                  res_id_ff   <= '0;
                  state_ff    <= S_RESP;
                  unique case (req_operation)
                     jpq_pkg::OP_ADD: begin
                        if (!req_job_idle) begin
                           res_status_ff <= jpq_pkg::STATUS_BUSY;
                           res_id_ff     <= '1;
                        end else if (occ_ff == CW'(QUEUE_DEPTH)) begin
                           res_status_ff <= jpq_pkg::STATUS_FULL;
                           res_id_ff     <= '1;
                        end else begin
                           res_status_ff <= jpq_pkg::STATUS_OK;
                           res_id_ff     <= next_id_ff;
                           key_id_ff     <= next_id_ff;
                           next_id_ff    <= next_id_ff + IW'(1);
                           idx_ff        <= occ_ff;
                           state_ff      <= (occ_ff == '0) ? S_ADD_PUT : S_ADD_CMP;
                        end
                     end
                     jpq_pkg::OP_TAKE: begin
                        if (occ_ff == '0) begin
                           res_status_ff <= jpq_pkg::STATUS_NONE;
                        end else begin
                           idx_ff   <= CW'(1);
                           state_ff <= S_TAKE_HEAD;
                        end
                     end
                     jpq_pkg::OP_FIND: begin
                        if (occ_ff == '0) begin
                           res_status_ff <= jpq_pkg::STATUS_NONE;
                        end else begin
                           idx_ff   <= '0;
                           state_ff <= S_FIND;
                        end
                     end
                     jpq_pkg::OP_CLEAR: begin
                        res_status_ff <= jpq_pkg::STATUS_OK;
                        occ_ff        <= '0;
                     end
                     default: begin
                        res_status_ff <= jpq_pkg::STATUS_OK;
                     end
                  endcase
               end
            end

            S_ADD_CMP: begin
               // rd_data holds the entry at idx - 1
               if (cmp.prio_lower) begin
                  idx_ff <= idx_ff - CW'(1);
                  if (idx_ff == CW'(1)) begin
                     state_ff <= S_ADD_PUT;
                  end
               end else begin
                  occ_ff   <= occ_ff + CW'(1);
                  state_ff <= S_RESP;
               end
            end

            S_ADD_PUT: begin
               occ_ff   <= occ_ff + CW'(1);
               state_ff <= S_RESP;
            end

            S_TAKE_HEAD: begin
               res_status_ff <= jpq_pkg::STATUS_OK;
               res_id_ff     <= ent_id;
               res_tag_ff    <= ent_tag;
               if (occ_ff == CW'(1)) begin
                  occ_ff   <= '0;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_TAKE_SHIFT;
               end
            end

            S_TAKE_SHIFT: begin
               if (last_idx) begin
                  occ_ff   <= occ_ff - CW'(1);
                  state_ff <= S_RESP;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
               end
            end

            S_FIND: begin
               // first match nearest the head wins
               if (cmp.id_match) begin
                  res_status_ff <= jpq_pkg::STATUS_OK;
                  res_id_ff     <= ent_id;
                  res_tag_ff    <= ent_tag;
                  state_ff      <= S_RESP;
               end else if (last_idx) begin
                  res_status_ff <= jpq_pkg::STATUS_NONE;
                  state_ff      <= S_RESP;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
               end
            end

            S_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= res_status_ff;
                  rsp_job_id_ff  <= res_id_ff;
                  rsp_out_tag_ff <= res_tag_ff;
                  rsp_count_ff   <= occ_ff;
                  state_ff       <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_job_id      = rsp_job_id_ff;
   assign rsp_out_tag     = rsp_out_tag_ff;
   assign rsp_queue_count = rsp_count_ff;
   assign rsp_nonempty    = (rsp_count_ff != '0);

endmodule

// File: rtl/jpq_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpq_entry_ram
// Entry store of the queue: one write port, one read port with registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module jpq_entry_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 51
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/jpq_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpq_cmp
// Shared compare unit: checks one stored entry against the key of the
// transaction in progress (priority order for insert, id match for find).
// ----------------------------------------------------------------------------
module jpq_cmp #(
   parameter int PRIORITY_BITS = 3
) (
   input  logic [PRIORITY_BITS-1:0]    entry_prio,
   input  logic [jpq_pkg::ID_BITS-1:0] entry_id,
   input  logic [PRIORITY_BITS-1:0]    key_prio,
   input  logic [jpq_pkg::ID_BITS-1:0] key_id,
   output jpq_pkg::cmp_result_type     result
);

   always_comb begin
      result.prio_lower = (entry_prio < key_prio);
      result.id_match   = (entry_id == key_id);
   end

endmodule

// File: rtl/jpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpq_checker
// Port-level checks on the response channel of the job priority queue.
// ----------------------------------------------------------------------------
module jpq_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [jpq_pkg::STATUS_BITS-1:0]     rsp_status,
   input logic [jpq_pkg::ID_BITS-1:0]         rsp_job_id,
   input logic [$clog2(QUEUE_DEPTH+1)-1:0]    rsp_queue_count,
   input logic                                rsp_nonempty
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_job_id) && $stable(rsp_status))
      else $error("response changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_queue_count <= CW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_nonempty == (rsp_queue_count != '0))
      else $error("nonempty flag disagrees with count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == jpq_pkg::STATUS_FULL |-> rsp_queue_count == CW'(QUEUE_DEPTH))
      else $error("full rejection with room in the queue");

   a_reject_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == jpq_pkg::STATUS_FULL || rsp_status == jpq_pkg::STATUS_BUSY)
      |-> rsp_job_id == '1)
      else $error("rejected add without all-ones id");

endmodule

bind job_priority_queue_core jpq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_jpq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_job_id      (rsp_job_id),
   .rsp_queue_count (rsp_queue_count),
   .rsp_nonempty    (rsp_nonempty)
);
